// ----- sv/addressed_command_holding_queue_macros.svh -----
// Assertion macros used by the holding queue top module.
`ifndef ADDRESSED_COMMAND_HOLDING_QUEUE_MACROS_SVH
`define ADDRESSED_COMMAND_HOLDING_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define ACQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define ACQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/acq_pkg.sv -----
// Shared types, constants and helpers of the addressed command holding queue.
`timescale 1ns / 1ps
package acq_pkg;

	localparam int SLOTS     = 8;
	localparam int MAX_BYTES = 32;

	localparam int SLOT_W  = 4;
	localparam int SIDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LEN_W   = 6;
	localparam int DEPTH   = SLOTS * MAX_BYTES;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STEP_W  = $clog2(SLOTS + 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [SIDX_W-1:0] sidx_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [7:0]        byte_t;
	typedef logic [1:0]        status_t;

	localparam slot_t NONE_SLOT = {SLOT_W{1'b1}};

	localparam status_t ST_SENT   = 2'd0;
	localparam status_t ST_STORED = 2'd1;
	localparam status_t ST_FULL   = 2'd2;
	localparam status_t ST_NONE   = 2'd3;

	// Commands from the sequencer to the slot table.
	typedef struct packed {
		logic  commit;
		logic  unlink;
		logic  dest_we;
		slot_t slot;
		len_t  len;
		byte_t dest;
	} acq_tbl_cmd_t;

	// Slot table entry seen at the command slot.
	typedef struct packed {
		len_t  len;
		byte_t dest;
		slot_t nxt;
	} acq_tbl_rd_t;

	function automatic logic slot_ok(slot_t s);
		return s < SLOT_W'(SLOTS);
	endfunction

	function automatic sidx_t slot_idx(slot_t s);
		return s[SIDX_W-1:0];
	endfunction

	function automatic addr_t store_addr(slot_t s, len_t i);
		return ADDR_W'(int'(s) * MAX_BYTES + int'(i));
	endfunction

endpackage

// ----- sv/acq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module acq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/acq_slot_table.sv -----
// Slot table: lengths, destinations and the arrival-ordered doubly linked list.
`timescale 1ns / 1ps
module acq_slot_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  acq_pkg::acq_tbl_cmd_t     cmd,
	output acq_pkg::slot_t            oldest,
	output logic [acq_pkg::SLOTS-1:0] idle_mask,
	output acq_pkg::acq_tbl_rd_t      rd
);
	import acq_pkg::*;

	len_t  len_q  [SLOTS];
	byte_t dest_q [SLOTS];
	slot_t next_q [SLOTS];
	slot_t prev_q [SLOTS];
	slot_t oldest_q;
	slot_t newest_q;

	sidx_t si;
	slot_t nx;
	slot_t pv;

	assign si = slot_idx(cmd.slot);
	assign nx = slot_ok(cmd.slot) ? next_q[si] : NONE_SLOT;
	assign pv = slot_ok(cmd.slot) ? prev_q[si] : NONE_SLOT;
	assign oldest = oldest_q;

	// A slot is idle while its length is zero.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			idle_mask[i] = (len_q[i] == '0);
		end
	end

	// Entry at the command slot; an invalid slot reads as empty.
	always_comb begin
		if (slot_ok(cmd.slot)) begin
			rd.len  = len_q[si];
			rd.dest = dest_q[si];
			rd.nxt  = next_q[si];
		end else begin
			rd.len  = '0;
			rd.dest = '0;
			rd.nxt  = NONE_SLOT;
		end
	end

	// Destination byte of the message being received.
	always_ff @(posedge clk) begin
		if (cmd.dest_we) begin
			dest_q[si] <= cmd.dest;
		end
	end

	// Append at the tail on commit; unlink and free on removal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				len_q[i]  <= '0;
				next_q[i] <= NONE_SLOT;
				prev_q[i] <= NONE_SLOT;
			end
			oldest_q <= NONE_SLOT;
			newest_q <= NONE_SLOT;
		end else begin
			if (cmd.commit) begin
				len_q[si]  <= cmd.len;
				next_q[si] <= NONE_SLOT;
				prev_q[si] <= newest_q;
				if (slot_ok(newest_q)) begin
					next_q[slot_idx(newest_q)] <= cmd.slot;
				end
				newest_q <= cmd.slot;
				if (!slot_ok(oldest_q)) begin
					oldest_q <= cmd.slot;
				end
			end
			if (cmd.unlink) begin
				if (slot_ok(nx)) begin
					prev_q[slot_idx(nx)] <= pv;
				end
				if (slot_ok(pv)) begin
					next_q[slot_idx(pv)] <= nx;
				end
				if (oldest_q == cmd.slot) begin
					oldest_q <= nx;
				end
				if (newest_q == cmd.slot) begin
					newest_q <= pv;
				end
				len_q[si]  <= '0;
				next_q[si] <= NONE_SLOT;
				prev_q[si] <= NONE_SLOT;
			end
		end
	end

endmodule

// ----- sv/addressed_command_holding_queue.sv -----
// A store byte is handled at its transfer; the last byte's result strobes in the next cycle.
// A poll walks one linked slot per cycle from the oldest until the match, the end of the list
// or the step limit, then streams one byte per cycle and unlinks the slot.
// A matching poll stays busy through walk, stream and unlink; a miss only for the walk.
// Results cannot be stalled by the receiver. Reset clears the slot table and the sequencer;
// message bytes need no clearing.
`timescale 1ns / 1ps
`include "addressed_command_holding_queue_macros.svh"
module addressed_command_holding_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [7:0]        msg_byte,
	input  logic              msg_last,
	input  logic [7:0]        poll_address,
	output logic              strobe,
	output acq_pkg::status_t  status,
	output logic [7:0]        out_byte,
	output logic              out_last
);
	import acq_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK   = 2'd1;
	localparam logic [1:0] S_STREAM = 2'd2;
	localparam logic [1:0] S_UNLINK = 2'd3;

	logic [1:0]        state_q;
	slot_t             walk_s_q;
	logic [STEP_W-1:0] steps_q;
	byte_t             addr_q;
	len_t              len_q;
	len_t              idx_q;
	len_t              fill_count_q;
	slot_t             filling_q;

	logic              res_v_q;
	status_t           res_status_q;
	logic              res_ram_q;
	logic              res_last_q;

	acq_tbl_cmd_t      cmd;
	acq_tbl_rd_t       rd;
	slot_t             oldest;
	logic [SLOTS-1:0]  idle_mask;
	byte_t             ram_rdata;

	logic              acc;
	logic              store_acc;
	slot_t             found;
	slot_t             cur_slot;
	logic              cur_ok;
	logic              room;
	len_t              new_cnt;
	logic              walk_end;
	logic              walk_hit;
	logic              stream_last;

	assign busy      = (state_q != S_IDLE);
	assign acc       = start && !busy;
	assign store_acc = acc && !action;

	// First idle slot, lowest index first.
	always_comb begin
		found = NONE_SLOT;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (idle_mask[i]) begin
				found = SLOT_W'(i);
			end
		end
	end

	// Slot and byte count of the message being received.
	assign cur_slot = (fill_count_q == '0) ? found : filling_q;
	assign cur_ok   = slot_ok(cur_slot);
	assign room     = fill_count_q < LEN_W'(MAX_BYTES);
	assign new_cnt  = cur_ok ? (room ? fill_count_q + 1'b1 : fill_count_q) : LEN_W'(1);

	// Compare of the walk: end of list or step limit, or a live slot with the polled address.
	assign walk_end    = (steps_q == STEP_W'(SLOTS)) || !slot_ok(walk_s_q);
	assign walk_hit    = (rd.len != '0) && (rd.dest == addr_q);
	assign stream_last = (idx_q == len_q - 1'b1);

	// Slot table commands.
	always_comb begin
		cmd.commit  = store_acc && msg_last && cur_ok;
		cmd.unlink  = (state_q == S_UNLINK);
		cmd.dest_we = store_acc && cur_ok && (fill_count_q == '0);
		cmd.slot    = store_acc ? cur_slot : walk_s_q;
		cmd.len     = new_cnt;
		cmd.dest    = msg_byte;
	end

	acq_slot_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.oldest    (oldest),
		.idle_mask (idle_mask),
		.rd        (rd)
	);

	acq_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_acc && cur_ok && room),
		.waddr (store_addr(cur_slot, fill_count_q)),
		.wdata (msg_byte),
		.raddr (store_addr(walk_s_q, idx_q)),
		.rdata (ram_rdata)
	);

	// Receive state of the message in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
			filling_q    <= NONE_SLOT;
		end else if (store_acc) begin
			if (msg_last) begin
				fill_count_q <= '0;
				filling_q    <= NONE_SLOT;
			end else begin
				fill_count_q <= new_cnt;
				filling_q    <= cur_slot;
			end
		end
	end

	// Poll sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			walk_s_q     <= NONE_SLOT;
			steps_q      <= '0;
			addr_q       <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			res_v_q      <= 1'b0;
			res_status_q <= ST_NONE;
			res_ram_q    <= 1'b0;
			res_last_q   <= 1'b0;
		end else begin
			res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (store_acc && msg_last) begin
						res_v_q      <= 1'b1;
						res_status_q <= cur_ok ? ST_STORED : ST_FULL;
						res_ram_q    <= 1'b0;
						res_last_q   <= 1'b1;
					end else if (acc && action) begin
						if (poll_address == '0) begin
							res_v_q      <= 1'b1;
							res_status_q <= ST_NONE;
							res_ram_q    <= 1'b0;
							res_last_q   <= 1'b1;
						end else begin
							walk_s_q <= oldest;
							steps_q  <= '0;
							addr_q   <= poll_address;
							state_q  <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (walk_end) begin
						res_v_q      <= 1'b1;
						res_status_q <= ST_NONE;
						res_ram_q    <= 1'b0;
						res_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end else if (walk_hit) begin
						len_q   <= rd.len;
						idx_q   <= '0;
						state_q <= S_STREAM;
					end else begin
						walk_s_q <= rd.nxt;
						steps_q  <= steps_q + 1'b1;
					end
				end
				S_STREAM: begin
					res_v_q      <= 1'b1;
					res_status_q <= ST_SENT;
					res_ram_q    <= 1'b1;
					res_last_q   <= stream_last;
					idx_q        <= idx_q + 1'b1;
					if (stream_last) begin
						state_q <= S_UNLINK;
					end
				end
				S_UNLINK: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result ports; the byte comes straight from the registered store read.
	assign strobe   = res_v_q;
	assign status   = res_status_q;
	assign out_byte = res_ram_q ? ram_rdata : 8'h00;
	assign out_last = res_last_q;

	`ACQ_ASSERT_NEXT(a_stream_emits, state_q == S_STREAM, strobe && status == ST_SENT, "no stream byte")
	`ACQ_ASSERT_NOW(a_unlink_last, state_q == S_UNLINK, strobe && out_last, "no last byte at unlink")
	`ACQ_ASSERT_NEXT(a_middle_quiet, store_acc && !msg_last, !strobe, "middle byte gave a result")
	`ACQ_ASSERT_NEXT(a_poll_progress, acc && action, busy || (strobe && out_last), "poll stalled")

endmodule

// ----- test/addressed_command_holding_queue_tb.sv -----
// Self-checking testbench for the addressed command holding queue.
`timescale 1ns / 1ps
module addressed_command_holding_queue_tb;
	import acq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 2 * (SLOTS + MAX_BYTES + 4);
	localparam int RANDOM_ITEMS = 110;

	typedef enum logic { OP_STORE = 1'b0, OP_POLL = 1'b1 } op_kind_t;

	typedef struct {
		op_kind_t kind;
		byte_t    msg_byte;
		logic     msg_last;
		byte_t    poll_address;
		int       idle_before;
	} queue_op_t;

	typedef struct {
		status_t status;
		byte_t   out_byte;
		logic    out_last;
	} queue_reply_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    action = 1'b0;
	logic    [7:0] msg_byte = 8'h00;
	logic    msg_last = 1'b0;
	logic    [7:0] poll_address = 8'h00;
	logic    busy;
	logic    strobe;
	status_t status;
	logic    [7:0] out_byte;
	logic    out_last;

	queue_op_t    pending_ops[$];
	queue_reply_t awaited_replies[$];
	byte_t        used_dests[$];
	logic         start_taken = 1'b0;
	int           idle_count = 0;
	int           errors = 0;
	int           cycle_count = 0;
	int           planned_items = 0;
	logic         quiet_tail = 1'b0;

	// Shadow copy of the slot table and linked list.
	byte_t held_bytes [SLOTS][MAX_BYTES];
	len_t  held_len [SLOTS];
	slot_t link_next [SLOTS];
	slot_t link_prev [SLOTS];
	slot_t head_slot;
	slot_t tail_slot;
	slot_t fill_slot;
	len_t  fill_len;

	addressed_command_holding_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.msg_byte     (msg_byte),
		.msg_last     (msg_last),
		.poll_address (poll_address),
		.strobe       (strobe),
		.status       (status),
		.out_byte     (out_byte),
		.out_last     (out_last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic void clear_shadow_queue();
		for (int s = 0; s < SLOTS; s++) begin
			held_len[s] = '0;
			link_next[s] = NONE_SLOT;
			link_prev[s] = NONE_SLOT;
		end
		head_slot = NONE_SLOT;
		tail_slot = NONE_SLOT;
		fill_slot = NONE_SLOT;
		fill_len = '0;
	endfunction

	function automatic void await_reply(status_t st, byte_t b, logic last);
		queue_reply_t r;
		r.status = st;
		r.out_byte = b;
		r.out_last = last;
		awaited_replies.push_back(r);
	endfunction

	// Update the shadow queue for one accepted transfer and queue the replies it causes.
	function automatic void predict_queue_response(op_kind_t kind, byte_t b, logic last,
			byte_t addr);
		slot_t s;
		slot_t nx;
		slot_t pv;
		logic  hit;
		if (kind == OP_STORE) begin
			// A new message claims the lowest idle slot, if any.
			if (fill_len == 0) begin
				fill_slot = NONE_SLOT;
				for (int k = SLOTS - 1; k >= 0; k--)
					if (held_len[k] == 0)
						fill_slot = slot_t'(k);
			end
			if (fill_slot < SLOTS) begin
				if (fill_len < MAX_BYTES) begin
					held_bytes[fill_slot][fill_len] = b;
					fill_len++;
				end
			end else begin
				fill_len = 1;
			end
			if (last) begin
				if (fill_slot < SLOTS) begin
					held_len[fill_slot] = fill_len;
					link_next[fill_slot] = NONE_SLOT;
					link_prev[fill_slot] = tail_slot;
					if (tail_slot < SLOTS)
						link_next[tail_slot] = fill_slot;
					tail_slot = fill_slot;
					if (!(head_slot < SLOTS))
						head_slot = fill_slot;
					await_reply(ST_STORED, 8'h00, 1'b1);
				end else begin
					await_reply(ST_FULL, 8'h00, 1'b1);
				end
				fill_len = '0;
				fill_slot = NONE_SLOT;
			end
		end else begin
			// Walk from the oldest entry; the first matching message is sent and unlinked.
			s = head_slot;
			hit = 1'b0;
			if (addr != 0) begin
				for (int k = 0; k < SLOTS && s < SLOTS && !hit; k++) begin
					if (held_len[s] != 0 && held_bytes[s][0] == addr) begin
						hit = 1'b1;
						for (int i = 0; i < held_len[s]; i++)
							await_reply(ST_SENT, held_bytes[s][i], i + 1 == held_len[s]);
						nx = link_next[s];
						pv = link_prev[s];
						if (nx < SLOTS)
							link_prev[nx] = pv;
						if (pv < SLOTS)
							link_next[pv] = nx;
						if (head_slot == s)
							head_slot = nx;
						if (tail_slot == s)
							tail_slot = pv;
						held_len[s] = '0;
						link_next[s] = NONE_SLOT;
						link_prev[s] = NONE_SLOT;
					end else begin
						s = link_next[s];
					end
				end
			end
			if (!hit)
				await_reply(ST_NONE, 8'h00, 1'b1);
		end
	endfunction

	function automatic int pick_idle();
		if (quiet_tail || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 13);
	endfunction

	function automatic void plan_byte(byte_t b, logic last);
		queue_op_t op;
		op.kind = OP_STORE;
		op.msg_byte = b;
		op.msg_last = last;
		op.poll_address = byte_t'($urandom_range(0, 255));
		op.idle_before = pick_idle();
		pending_ops.push_back(op);
	endfunction

	function automatic void plan_poll(byte_t addr);
		queue_op_t op;
		op.kind = OP_POLL;
		op.msg_byte = byte_t'($urandom_range(0, 255));
		op.msg_last = 1'($urandom_range(0, 1));
		op.poll_address = addr;
		op.idle_before = pick_idle();
		pending_ops.push_back(op);
		planned_items++;
	endfunction

	// A whole message: destination first, random body, last flag on the final byte.
	function automatic void plan_message(byte_t dest, int len);
		for (int i = 0; i < len; i++) begin
			plan_byte(i == 0 ? dest : byte_t'($urandom_range(0, 255)), i == len - 1);
			if (i < MAX_BYTES)
				planned_items++;
		end
		used_dests.push_back(dest);
	endfunction

	function automatic byte_t pick_dest();
		byte_t favorites [6] = '{8'h01, 8'h02, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		if ($urandom_range(0, 9) < 7)
			return favorites[$urandom_range(0, 5)];
		return byte_t'($urandom_range(0, 255));
	endfunction

	function automatic byte_t pick_poll_address();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 2)
			return 8'h00;
		if (roll < 5 || used_dests.size() == 0)
			return byte_t'($urandom_range(0, 255));
		return used_dests[$urandom_range(0, used_dests.size() - 1)];
	endfunction

	// Drive the next transfer once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!start || start_taken)) begin
			if (pending_ops.size() == 0) begin
				start <= 1'b0;
			end else if (idle_count < pending_ops[0].idle_before) begin
				start <= 1'b0;
				idle_count <= idle_count + 1;
			end else begin
				start <= 1'b1;
				action <= pending_ops[0].kind;
				msg_byte <= pending_ops[0].msg_byte;
				msg_last <= pending_ops[0].msg_last;
				poll_address <= pending_ops[0].poll_address;
				idle_count <= 0;
				void'(pending_ops.pop_front());
			end
		end
	end

	// Check each strobed result against the oldest expectation, then predict new transfers.
	always @(posedge clk) begin : watch_results
		queue_reply_t want;
		if (arst_n) begin
			if (strobe) begin
				if (awaited_replies.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: status %0d byte 0x%02h last %0d",
						$time, status, out_byte, out_last);
				end else begin
					want = awaited_replies.pop_front();
					if (status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, status);
					end
					if (out_byte !== want.out_byte) begin
						errors++;
						$display("%0t: out_byte expected 0x%02h, actual 0x%02h",
							$time, want.out_byte, out_byte);
					end
					if (out_last !== want.out_last) begin
						errors++;
						$display("%0t: out_last expected %0d, actual %0d",
							$time, want.out_last, out_last);
					end
				end
			end
			start_taken <= start && !busy;
			if (start && !busy)
				predict_queue_response(op_kind_t'(action), msg_byte, msg_last, poll_address);
		end
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("addressed_command_holding_queue_tb: FAIL");
		$finish;
	end

	initial begin
		int roll;
		clear_shadow_queue();

		// Directed part: empty polls, address zero, extremes, a full queue and unlinks.
		plan_poll(8'h00);
		plan_poll(8'hFF);
		plan_message(8'hFF, 1);
		plan_byte(8'h01, 1'b0);
		plan_byte(8'h00, 1'b0);
		plan_byte(8'hFF, 1'b1);
		plan_poll(8'h01);
		plan_poll(8'hFF);
		for (int i = 0; i < SLOTS; i++)
			plan_message(byte_t'(8'h11 + i), 1);
		plan_byte(8'h20, 1'b0);
		plan_byte(8'h55, 1'b1);
		plan_poll(8'h77);
		plan_poll(8'h14);
		plan_poll(8'h11);
		plan_poll(byte_t'(8'h10 + SLOTS));

		// Random part: mostly well-formed messages and polls, some broken byte runs.
		plan_message(pick_dest(), $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8));
		while (planned_items < RANDOM_ITEMS) begin
			quiet_tail = planned_items >= RANDOM_ITEMS - 20;
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				plan_message(pick_dest(), $urandom_range(1, 6));
			end else if (roll < 53) begin
				plan_message(pick_dest(), $urandom_range(MAX_BYTES - 1, MAX_BYTES + 4));
			end else if (roll < 88) begin
				plan_poll(pick_poll_address());
			end else begin
				repeat ($urandom_range(1, 3)) begin
					plan_byte(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					planned_items++;
				end
			end
		end
		// Close any message left open by a broken run.
		plan_message(pick_dest(), 1);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_ops.size() != 0 || start || awaited_replies.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (awaited_replies.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, awaited_replies.size());
		end
		if (errors == 0)
			$display("addressed_command_holding_queue_tb: PASS");
		else
			$display("addressed_command_holding_queue_tb: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/acq_pkg.sv
sv/acq_ram.sv
sv/acq_slot_table.sv
sv/addressed_command_holding_queue.sv
test/addressed_command_holding_queue_tb.sv
